/* rtl/core/b2da_pkg.sv */
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared widths, character codes and status types for the binary to decimal
// ascii converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  // width of the converted value
  localparam int VALUE_BITS = 64;

  // decimal digits needed for the largest unsigned value (ceil of bits * log10 2)
  localparam int NUM_DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;
  localparam int BCD_BITS   = 4 * NUM_DIGITS;

  // counter widths
  localparam int BIT_CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int REM_W     = $clog2(NUM_DIGITS + 1);

  // character codes
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  // status of the shift-and-add-3 converter towards the character emitter
  typedef struct packed {
    logic busy;
    logic done;
    logic neg;
  } dab_stat_t;

endpackage

/* rtl/core/b2da_dabble.sv */
// ----------------------------------------------------------------------------
// b2da_dabble
// Bit-serial binary to bcd converter: one magnitude bit enters the bcd shift
// register per cycle, every digit corrected by add-3 before the shift.
// ----------------------------------------------------------------------------
module b2da_dabble (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [b2da_pkg::VALUE_BITS-1:0]   mag,
  input  logic                              neg_in,
  output logic [b2da_pkg::BCD_BITS-1:0]     bcd,
  output b2da_pkg::dab_stat_t               stat
);

  logic [b2da_pkg::VALUE_BITS-1:0] sh;
  logic [b2da_pkg::BIT_CNT_W-1:0]  cnt;
  logic [b2da_pkg::BCD_BITS-1:0]   bcd_adj;
  logic                            busy;
  logic                            done;
  logic                            neg;
  logic                            final_bit;

  // add 3 to every digit of 5 or more, digits are independent
  always_comb begin
    bcd_adj = bcd;
    for (int i = 0; i < b2da_pkg::NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
  end

  // last magnitude bit goes in this cycle
  assign final_bit = busy && !start &&
                     (cnt == b2da_pkg::BIT_CNT_W'(b2da_pkg::VALUE_BITS - 1));

  // control: bit counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= final_bit;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (final_bit) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath: magnitude shifts out msb first into the bcd register
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= mag;
      bcd <= '0;
      neg <= neg_in;
    end else if (busy) begin
      sh  <= {sh[b2da_pkg::VALUE_BITS-2:0], 1'b0};
      bcd <= {bcd_adj[b2da_pkg::BCD_BITS-2:0], sh[b2da_pkg::VALUE_BITS-1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.neg  = neg;

endmodule

/* rtl/core/b2da_emit.sv */
// ----------------------------------------------------------------------------
// b2da_emit
// Character emitter: shifts bcd digits out most significant first, drops
// leading zeros, puts a minus sign in front and drives the output register.
// ----------------------------------------------------------------------------
module b2da_emit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic [b2da_pkg::BCD_BITS-1:0]   bcd,
  input  logic                            neg,
  output logic                            busy,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      ascii_char,
  output logic                            last
);

  logic [b2da_pkg::BCD_BITS-1:0] digits;
  logic [b2da_pkg::REM_W-1:0]    rem;
  logic                          active;
  logic                          neg_pend;
  logic                          started;
  logic                          take;
  logic [3:0]                    top;
  logic                          skip;
  logic                          send;

  // output register free or being emptied this cycle
  assign take = !out_valid || !out_stall;
  assign top  = digits[b2da_pkg::BCD_BITS-1 -: 4];
  assign skip = !started && (top == 4'd0) && (rem > b2da_pkg::REM_W'(1));
  assign busy = active;

  // a character enters the output register this cycle
  assign send = active && !load && take && (neg_pend || !skip);

  // control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      neg_pend  <= 1'b0;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= send || (out_valid && out_stall);
      if (load) begin
        active   <= 1'b1;
        neg_pend <= neg;
        started  <= 1'b0;
      end else if (active) begin
        priority if (neg_pend) begin
          if (take) begin
            neg_pend  <= 1'b0;
          end
        end else if (skip) begin
          // leading zero, nothing to send
        end else if (take) begin
          started   <= 1'b1;
          if (rem == b2da_pkg::REM_W'(1)) begin
            active <= 1'b0;
          end
        end
      end
    end
  end

  // digit shift register, remaining count and character payload
  always_ff @(posedge clk) begin
    if (load) begin
      digits <= bcd;
      rem    <= b2da_pkg::REM_W'(b2da_pkg::NUM_DIGITS);
    end else if (active) begin
      priority if (neg_pend) begin
        if (take) begin
          ascii_char <= b2da_pkg::ASCII_MINUS;
          last       <= 1'b0;
        end
      end else if (skip) begin
        digits <= {digits[b2da_pkg::BCD_BITS-5:0], 4'd0};
        rem    <= rem - 1'b1;
      end else if (take) begin
        ascii_char <= b2da_pkg::ASCII_ZERO + {4'd0, top};
        last       <= (rem == b2da_pkg::REM_W'(1));
        digits     <= {digits[b2da_pkg::BCD_BITS-5:0], 4'd0};
        rem        <= rem - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/binary_to_decimal_ascii_top.sv */
// One request carries a 64-bit value and a flag that marks it as two's
// complement; the block answers with the decimal text as ascii characters,
// most significant first, with a leading '-' for a negative signed value,
// leading zeros dropped (zero gives a single '0') and last set on the final
// character. Requests are handled one at a time: the magnitude runs through a
// bit-serial shift-and-add-3 converter, then the digits are handed to the
// emitter, which walks all 20 digit slots, dropping leading zeros and sending
// the remaining characters after an optional minus sign, waiting on stalls.
// The next request is taken at the edge after the last character reaches the
// output register.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// Binary to decimal ascii converter: sign handling, bit-serial bcd conversion
// and character emission with a registered output.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] value,
  input  logic        is_signed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  ascii_char,
  output logic        last
);

  logic [b2da_pkg::VALUE_BITS-1:0] v;
  logic [b2da_pkg::VALUE_BITS-1:0] mag;
  logic                            neg;
  logic                            accept;
  logic [b2da_pkg::BCD_BITS-1:0]   bcd;
  b2da_pkg::dab_stat_t             dab_stat;
  logic                            emit_busy;

  // magnitude of the masked value, most negative value comes out unsigned
  assign v      = value[b2da_pkg::VALUE_BITS-1:0];
  assign neg    = is_signed && v[b2da_pkg::VALUE_BITS-1];
  assign mag    = neg ? (~v + 1'b1) : v;

  // one request in flight until its characters reach the output register
  assign in_stall = dab_stat.busy || dab_stat.done || emit_busy;
  assign accept   = in_valid && !in_stall;

  b2da_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .mag    (mag),
    .neg_in (neg),
    .bcd    (bcd),
    .stat   (dab_stat)
  );

  b2da_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (dab_stat.done),
    .bcd        (bcd),
    .neg        (dab_stat.neg),
    .busy       (emit_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ascii_char (ascii_char),
    .last       (last)
  );

  // converter and emitter never work at the same time
  assert property (@(posedge clk) disable iff (rst) !(dab_stat.busy && emit_busy))
    else $error("converter and emitter both busy");

  // an accepted request starts the converter
  assert property (@(posedge clk) disable iff (rst) accept |=> dab_stat.busy)
    else $error("accepted request did not start conversion");

  // only a minus sign or a decimal digit leaves the block
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ascii_char == b2da_pkg::ASCII_MINUS ||
                   (ascii_char >= b2da_pkg::ASCII_ZERO && ascii_char <= 8'd57)))
    else $error("character out of range");

  // the minus sign is never the final character
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && ascii_char == b2da_pkg::ASCII_MINUS) |-> !last)
    else $error("minus sign marked last");

endmodule

/* dv/tb_binary_to_decimal_ascii_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii_top
// Self-checking bench for the binary to decimal ascii converter. Directed
// requests hit zero, single digits, powers of ten and the signed and unsigned
// extremes, then random values of mixed sizes follow. Both handshakes idle at
// random, with one stretch at full rate. Every character that leaves the block
// is checked against a local model of the decimal text.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii_top;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } text_char_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] value;
  logic        is_signed;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  ascii_char;
  logic        last;

  text_char_t  pending_chars[$];
  bit          no_idle;
  int          errors;
  int          requests_sent;
  int          negatives_sent;
  int          chars_checked;

  binary_to_decimal_ascii_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .is_signed  (is_signed),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ascii_char (ascii_char),
    .last       (last)
  );

  // clock, 10 ns period
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // hard limit on run length
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // count a mismatch, print only the first few
  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40)
      $display("mismatch at %0t: %s", $time, what);
  endtask

  // decimal text of one request, pushed onto the expected characters
  function automatic void predict_decimal_text(input logic [63:0] raw, input logic as_signed);
    logic [63:0] mask;
    logic [63:0] mag;
    logic        neg;
    logic [7:0]  digits[$];
    text_char_t  c;
    mask = (~64'd0) >> (64 - b2da_pkg::VALUE_BITS);
    mag  = raw & mask;
    neg  = as_signed && mag[b2da_pkg::VALUE_BITS-1];
    if (neg)
      mag = (~mag + 64'd1) & mask;
    do begin
      digits.push_front(b2da_pkg::ASCII_ZERO + 8'(mag % 64'd10));
      mag = mag / 64'd10;
    end while (mag != 64'd0 && digits.size() < b2da_pkg::NUM_DIGITS);
    if (neg) begin
      c.ch  = b2da_pkg::ASCII_MINUS;
      c.fin = 1'b0;
      pending_chars.push_back(c);
    end
    foreach (digits[i]) begin
      c.ch  = digits[i];
      c.fin = (i == digits.size() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // one request; entered and left at a falling edge
  task automatic send_request(input logic [63:0] v, input logic s);
    while (!no_idle && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    value     <= v;
    is_signed <= s;
    predict_decimal_text(v, s);
    requests_sent++;
    if (s && v[b2da_pkg::VALUE_BITS-1])
      negatives_sent++;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending until every expected character is out
  task automatic wait_drained;
    in_valid <= 1'b0;
    while (pending_chars.size() != 0)
      @(negedge clk);
  endtask

  // random value: full width, short, near a power of ten, small negative or
  // close to the sign and range boundaries
  function automatic logic [63:0] random_value;
    logic [63:0] full;
    logic [63:0] p;
    int          k;
    full = {$urandom, $urandom};
    case ($urandom_range(4))
      0: return full;
      1: return full >> $urandom_range(63);
      2: begin
        p = 64'd1;
        k = $urandom_range(19);
        repeat (k) p = p * 64'd10;
        return p + 64'd2 - 64'($urandom_range(4));
      end
      3: return ~(full >> $urandom_range(63, 40)) + 64'd1;
      default: begin
        if ($urandom_range(1))
          return {1'b1, 63'd0} + 64'($urandom_range(3)) - 64'($urandom_range(3));
        return ~64'd0 - 64'($urandom_range(5));
      end
    endcase
  endfunction

  // far side stall
  always @(negedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < 35);
  end

  // result check against the oldest expected character
  always @(posedge clk) begin : check_chars
    text_char_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last=%0b", ascii_char, last));
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (ascii_char !== want.ch)
          report_mismatch($sformatf("char 0x%02h, wanted 0x%02h", ascii_char, want.ch));
        if (last !== want.fin)
          report_mismatch($sformatf("last %0b, wanted %0b on char 0x%02h",
                                    last, want.fin, want.ch));
      end
    end
  end

  // zero, single digits and digit count steps
  task automatic test_zero_and_small;
    send_request(64'd0, 1'b0);
    send_request(64'd0, 1'b1);
    send_request(64'd1, 1'b0);
    send_request(64'd9, 1'b1);
    send_request(64'd10, 1'b0);
    send_request(64'd99, 1'b1);
    send_request(64'd100, 1'b0);
  endtask

  // unsigned extremes, powers of ten and alternating bit patterns
  task automatic test_unsigned_extremes;
    send_request(~64'd0, 1'b0);
    send_request(64'd10_000_000_000_000_000_000, 1'b0);
    send_request(64'd9_999_999_999_999_999_999, 1'b0);
    send_request(64'd100_000_000_000, 1'b0);
    send_request(64'd100_000, 1'b0);
    send_request({1'b1, 63'd0}, 1'b0);
    send_request(64'h5555_5555_5555_5555, 1'b0);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
  endtask

  // signed boundaries, including the most negative value
  task automatic test_signed_extremes;
    send_request(~64'd0, 1'b1);
    send_request({1'b1, 63'd0}, 1'b1);
    send_request({1'b1, 63'd1}, 1'b1);
    send_request({1'b0, {63{1'b1}}}, 1'b1);
    send_request(-64'sd10, 1'b1);
    send_request(-64'sd100_000, 1'b1);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
  endtask

  // random values with idling on both sides
  task automatic test_random_values(input int count);
    repeat (count)
      send_request(random_value(), 1'($urandom_range(1)));
  endtask

  // random values at full rate on both sides
  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    repeat (count)
      send_request(random_value(), 1'($urandom_range(1)));
    no_idle = 1'b0;
  endtask

  // block empties fully between two bursts
  task automatic test_drain_pause;
    repeat (5)
      send_request(random_value(), 1'($urandom_range(1)));
    wait_drained();
    repeat (5)
      send_request(random_value(), 1'($urandom_range(1)));
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    value     = 64'd0;
    is_signed = 1'b0;
    out_stall = 1'b0;
    no_idle   = 1'b0;
    errors    = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_zero_and_small();
    test_unsigned_extremes();
    test_signed_extremes();
    test_random_values(45);
    test_drain_pause();
    test_back_to_back(30);
    test_random_values(40);

    wait_drained();
    repeat (120) @(negedge clk);
    if (pending_chars.size() != 0)
      report_mismatch($sformatf("%0d chars never arrived", pending_chars.size()));

    $display("covered %0d requests (%0d negative), %0d characters checked",
             requests_sent, negatives_sent, chars_checked);
    $display("zero, digit count steps, signed and unsigned extremes, random sizes, %0d errors",
             errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/b2da_pkg.sv
rtl/core/b2da_dabble.sv
rtl/core/b2da_emit.sv
rtl/core/binary_to_decimal_ascii_top.sv
dv/tb_binary_to_decimal_ascii_top.sv
